@@ rtl/core/chc_pkg.sv @@
// Shared types, widths and constants of the color hue classifier.
// No dependencies.
`default_nettype none

package chc_pkg;

	localparam int PULSE_BITS   = 16;
	localparam int FRAC_BITS    = 14;
	localparam int TOL_W        = 8;
	localparam int HUE_W        = 10;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = PULSE_BITS;

	// normalizer: Q3.FRAC signed, quotient magnitude bits
	localparam int NORM_W       = FRAC_BITS + 3;
	localparam int QB           = NORM_W;
	localparam int MAG_W        = PULSE_BITS;
	localparam int REM_W        = MAG_W + FRAC_BITS;
	localparam int OVF_SH       = QB - FRAC_BITS;
	localparam int DIV_LAT      = QB + 2;
	localparam int NORM_LIM     = 1 << (FRAC_BITS + 2);

	// angle path
	localparam int ANG_FRAC     = 30;
	localparam int ANG_SH       = ANG_FRAC - FRAC_BITS;
	localparam int CORDIC_STEPS = 24;
	localparam int CW           = 40;
	localparam int AW           = 34;
	localparam int ANG_W        = 32;
	localparam int SQRT3_W      = 31;
	localparam logic [SQRT3_W-1:0] SQRT3_Q30   = 31'd1859775393;
	localparam logic [ANG_W-1:0]   PI_Q30      = 32'd3373259426;
	localparam logic [ANG_W-1:0]   HALF_PI_Q30 = 32'd1686629713;

	// degrees: floor(a * 18000 / (314 * 2^30)), 314 by reciprocal
	localparam int DEG_NUM_W    = 15;
	localparam int DEG_NUM      = 18000;
	localparam int DEG_DEN      = 314;
	localparam int DEG_Q_W      = ANG_W + DEG_NUM_W;
	localparam int DEG_M_W      = DEG_Q_W - ANG_FRAC;
	localparam int RECIP_SH     = 24;
	localparam int RECIP_W      = 16;
	localparam int RECIP_K      = ((1 << RECIP_SH) + DEG_DEN - 1) / DEG_DEN;
	localparam int DEG_D_W      = 9;
	localparam int FULL_TURN    = 360;
	localparam int HUE_NONE     = -500;

	localparam int FIFO_DEPTH   = 4;
	localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W   = $clog2(FIFO_DEPTH + 1);

	typedef struct packed {
		logic [PULSE_BITS-1:0] black_red;
		logic [PULSE_BITS-1:0] black_green;
		logic [PULSE_BITS-1:0] black_blue;
		logic [PULSE_BITS-1:0] white_red;
		logic [PULSE_BITS-1:0] white_green;
		logic [PULSE_BITS-1:0] white_blue;
	} cal_t;

	typedef struct packed {
		logic signed [NORM_W-1:0] r;
		logic signed [NORM_W-1:0] g;
		logic signed [NORM_W-1:0] b;
		logic [TOL_W-1:0]         tol;
	} norm_item_t;

	function automatic logic [ANG_W-1:0] atan_q30(input int i);
		logic [ANG_W-1:0] v;
		case (i)
			0:       v = 32'h3243F6A8;
			1:       v = 32'h1DAC6705;
			2:       v = 32'h0FADBAFC;
			3:       v = 32'h07F56EA6;
			4:       v = 32'h03FEAB76;
			5:       v = 32'h01FFD55B;
			6:       v = 32'h00FFFAAA;
			7:       v = 32'h007FFF55;
			8:       v = 32'h003FFFEA;
			9:       v = 32'h001FFFFD;
			10:      v = 32'h000FFFFF;
			11:      v = 32'h0007FFFF;
			12:      v = 32'h0003FFFF;
			13:      v = 32'h0001FFFF;
			14:      v = 32'h0000FFFF;
			15:      v = 32'h00007FFF;
			16:      v = 32'h00003FFF;
			17:      v = 32'h00001FFF;
			18:      v = 32'h00000FFF;
			19:      v = 32'h000007FF;
			20:      v = 32'h000003FF;
			21:      v = 32'h000001FF;
			22:      v = 32'h000000FF;
			23:      v = 32'h0000007F;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/chc_div.sv @@
// Pipelined restoring divider for one channel: (pulse-black)*2^FRAC/(white-black),
// truncated and saturated. Depends on chc_pkg.
`default_nettype none

module chc_div (
	input  logic                                 clk,
	input  logic                                 en,
	input  logic [chc_pkg::PULSE_BITS-1:0]       pulse,
	input  logic [chc_pkg::PULSE_BITS-1:0]       black,
	input  logic [chc_pkg::PULSE_BITS-1:0]       white,
	output logic signed [chc_pkg::NORM_W-1:0]    norm
);
	import chc_pkg::*;

	localparam int DIVW = REM_W + 3;

	logic signed [PULSE_BITS:0] num_d, den_d;
	logic [MAG_W-1:0]           num_m, den_m;

	logic [REM_W-1:0] rem_s [QB+1];
	logic [QB-1:0]    quo_s [QB+1];
	logic [MAG_W-1:0] den_s [QB+1];
	logic             neg_s [QB+1];
	logic             dz_s  [QB+1];
	logic             ovf_s [QB+1];

	logic [DIVW-1:0]  trial_c [QB];
	logic             ge_c    [QB];
	logic [REM_W-1:0] rnext_c [QB];
	logic [QB-1:0]    qnext_c [QB];

	logic signed [NORM_W-1:0] norm_s;

	always_comb begin
		num_d = $signed({1'b0, pulse}) - $signed({1'b0, black});
		den_d = $signed({1'b0, white}) - $signed({1'b0, black});
		num_m = num_d[PULSE_BITS] ? MAG_W'(-num_d) : MAG_W'(num_d);
		den_m = den_d[PULSE_BITS] ? MAG_W'(-den_d) : MAG_W'(den_d);
	end

	always_comb begin
		for (int j = 0; j < QB; j++) begin
			trial_c[j] = DIVW'(den_s[j]) << (QB - 1 - j);
			ge_c[j]    = DIVW'(rem_s[j]) >= trial_c[j];
			rnext_c[j] = ge_c[j] ? rem_s[j] - trial_c[j][REM_W-1:0] : rem_s[j];
			qnext_c[j] = quo_s[j] | (QB'(ge_c[j]) << (QB - 1 - j));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= {num_m, {FRAC_BITS{1'b0}}};
			quo_s[0] <= '0;
			den_s[0] <= den_m;
			neg_s[0] <= num_d[PULSE_BITS] ^ den_d[PULSE_BITS];
			dz_s[0]  <= (den_d == '0);
			ovf_s[0] <= (MAG_W + OVF_SH)'(num_m) >= ((MAG_W + OVF_SH)'(den_m) << OVF_SH);
			for (int j = 0; j < QB; j++) begin
				rem_s[j+1]              <= rnext_c[j];
				quo_s[j+1]              <= qnext_c[j];
				den_s[j+1]              <= den_s[j];
				neg_s[j+1]              <= neg_s[j];
				dz_s[j+1]               <= dz_s[j];
				ovf_s[j+1]              <= ovf_s[j];
			end
			if (dz_s[QB])
				norm_s <= '0;
			else if (!neg_s[QB])
				norm_s <= (ovf_s[QB] || quo_s[QB] > QB'(NORM_LIM - 1)) ?
					NORM_W'(NORM_LIM - 1) : $signed(quo_s[QB]);
			else
				norm_s <= (ovf_s[QB] || quo_s[QB] > QB'(NORM_LIM)) ?
					NORM_W'(-NORM_LIM) : -$signed(quo_s[QB]);
		end
	end

	assign norm = norm_s;

endmodule

`default_nettype wire

@@ rtl/core/chc_front.sv @@
// Front end: accepts transfers and normalizes the three channels in parallel.
// Depends on chc_pkg, chc_div.
`default_nettype none

module chc_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [chc_pkg::PULSE_BITS-1:0] pulse_red,
	input  logic [chc_pkg::PULSE_BITS-1:0] pulse_green,
	input  logic [chc_pkg::PULSE_BITS-1:0] pulse_blue,
	input  logic [chc_pkg::TOL_W-1:0]     tolerance,
	input  chc_pkg::cal_t                 cal,
	output logic                          out_valid,
	input  logic                          out_ready,
	output chc_pkg::norm_item_t           out_item
);
	import chc_pkg::*;

	logic                en;
	logic [DIV_LAT-1:0]  v_q;
	logic [TOL_W-1:0]    tol_s [DIV_LAT];
	logic signed [NORM_W-1:0] r_n, g_n, b_n;

	assign out_valid = v_q[DIV_LAT-1];
	assign en        = !out_valid || out_ready;
	assign in_ready  = en;

	chc_div u_div_r (.clk(clk), .en(en), .pulse(pulse_red), .black(cal.black_red),
		.white(cal.white_red), .norm(r_n));
	chc_div u_div_g (.clk(clk), .en(en), .pulse(pulse_green), .black(cal.black_green),
		.white(cal.white_green), .norm(g_n));
	chc_div u_div_b (.clk(clk), .en(en), .pulse(pulse_blue), .black(cal.black_blue),
		.white(cal.white_blue), .norm(b_n));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[DIV_LAT-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tol_s[0] <= tolerance;
			for (int j = 1; j < DIV_LAT; j++)
				tol_s[j] <= tol_s[j-1];
		end
	end

	assign out_item = '{r: r_n, g: g_n, b: b_n, tol: tol_s[DIV_LAT-1]};

endmodule

`default_nettype wire

@@ rtl/core/chc_fifo.sv @@
// Short register queue between the front end and the back end.
// Depends on chc_pkg.
`default_nettype none

module chc_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  chc_pkg::norm_item_t in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output chc_pkg::norm_item_t out_item
);
	import chc_pkg::*;

	norm_item_t            mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_q, rd_q;
	logic [FIFO_CNT_W-1:0] cnt_q;
	logic                  push, pop;

	assign in_ready  = cnt_q != FIFO_CNT_W'(FIFO_DEPTH);
	assign out_valid = cnt_q != '0;
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_item  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FIFO_CNT_W'(FIFO_DEPTH))
		else $error("queue count beyond depth");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0 || cnt_q == FIFO_CNT_W'(FIFO_DEPTH)) |-> wr_q == rd_q)
		else $error("queue pointers disagree with count");

	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("queue count missed a push");

endmodule

`default_nettype wire

@@ rtl/core/chc_back.sv @@
// Back end: CORDIC hue angle, conversion to degrees and red/blue window tests.
// Depends on chc_pkg.
`default_nettype none

module chc_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  chc_pkg::norm_item_t              in_item,
	input  logic signed [chc_pkg::HUE_W-1:0] red_center,
	input  logic signed [chc_pkg::HUE_W-1:0] blue_center,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [chc_pkg::HUE_W-1:0] hue,
	output logic                             matches_red,
	output logic                             matches_blue
);
	import chc_pkg::*;

	localparam int NB      = CORDIC_STEPS + 8;
	localparam int ST_CLMP = CORDIC_STEPS + 3;
	localparam int ST_MUL  = ST_CLMP + 1;
	localparam int ST_RCP  = ST_MUL + 1;
	localparam int ST_HUE  = ST_RCP + 1;
	localparam int ST_OUT  = ST_HUE + 1;
	localparam int XW      = NORM_W + 2;
	localparam int PW      = NORM_W + SQRT3_W;
	localparam int WW      = 14;
	localparam logic signed [WW-1:0] TURN = WW'(FULL_TURN);

	typedef struct packed {
		logic             eq;
		logic             gbz;
		logic             xpos;
		logic             bgt;
		logic [TOL_W-1:0] tol;
	} back_tag_t;

	function automatic logic signed [WW-1:0] half_trunc(input logic signed [WW-1:0] v);
		return v[WW-1] ? -((-v) >>> 1) : v >>> 1;
	endfunction

	function automatic logic signed [WW-1:0] wrap_turn(input logic signed [WW-1:0] v);
		if (v >= 2 * TURN)
			return v - 2 * TURN;
		else if (v >= TURN)
			return v - TURN;
		return v;
	endfunction

	function automatic logic in_red(input logic signed [WW-1:0] h, c, t);
		if (c > t && c < TURN - t)
			return h > c - t && h < c + t;
		if (c < t)
			return h >= c + TURN - t || h <= c + t;
		if (c > TURN - t)
			return h >= c - t || h <= wrap_turn(c + t);
		return 1'b0;
	endfunction

	function automatic logic in_blue(input logic signed [WW-1:0] h, c, t);
		logic signed [WW-1:0] lo, hi;
		lo = '0;
		hi = '0;
		if (c > t && c < TURN - t)
			return 2 * h > 2 * c - 3 * t && 2 * h < 2 * c + 3 * t;
		if (c < t) begin
			lo = half_trunc(2 * c + 3 * t);
			hi = half_trunc(2 * c + 2 * TURN - 3 * t);
			return h > hi || h < lo;
		end
		if (c > TURN - t) begin
			lo = wrap_turn(c + t);
			hi = half_trunc(2 * c - 3 * t);
			return h >= hi || h <= lo;
		end
		return 1'b0;
	endfunction

	logic           en;
	logic [NB-1:0]  v_q;
	back_tag_t      tag_s [NB];

	logic signed [XW-1:0]     x_c;
	logic signed [NORM_W:0]   gb_c;
	logic [NORM_W-1:0]        mag_c;

	logic signed [XW-1:0]     x_s1;
	logic [NORM_W-1:0]        mag_s1;
	logic [PW-1:0]            prod_c;
	logic signed [CW-1:0]     x_s2, y_s2;
	logic signed [CW-1:0]     cx_s [CORDIC_STEPS+1];
	logic signed [CW-1:0]     cy_s [CORDIC_STEPS+1];
	logic signed [AW-1:0]     ca_s [CORDIC_STEPS+1];

	logic signed [AW-1:0]     a_end;
	logic [ANG_W-1:0]         afin_c;
	logic [ANG_W-1:0]         a_s27;
	logic                     az_s27, az_s28, az_s29;
	logic [DEG_Q_W-1:0]       q_s28;
	logic [DEG_M_W+RECIP_W-1:0] dprod_c;
	logic [DEG_M_W-1:0]       m_s29, rm_c;
	logic [DEG_D_W-1:0]       d_s29;
	logic                     inx_s29, inexact_c;
	logic signed [HUE_W-1:0]  hue_c, hue_s30;
	logic signed [HUE_W-1:0]  hue_s31;
	logic                     mr_s31, mb_s31;
	logic signed [WW-1:0]     hw_c, tw_c;

	assign out_valid = v_q[NB-1];
	assign en        = !out_valid || out_ready;
	assign in_ready  = en;

	always_comb begin
		x_c   = (XW'(in_item.r) <<< 1) - XW'(in_item.g) - XW'(in_item.b);
		gb_c  = (NORM_W+1)'(in_item.g) - (NORM_W+1)'(in_item.b);
		mag_c = gb_c[NORM_W] ? NORM_W'(-gb_c) : NORM_W'(gb_c);
	end

	assign prod_c = PW'(mag_s1) * PW'(SQRT3_Q30);

	always_comb begin
		a_end = ca_s[CORDIC_STEPS];
		if (tag_s[ST_CLMP-1].gbz)
			afin_c = tag_s[ST_CLMP-1].xpos ? '0 : PI_Q30;
		else if (a_end < 0)
			afin_c = '0;
		else if (a_end > $signed(AW'(PI_Q30)))
			afin_c = PI_Q30;
		else
			afin_c = a_end[ANG_W-1:0];
	end

	assign dprod_c = (DEG_M_W+RECIP_W)'(q_s28[DEG_Q_W-1:ANG_FRAC]) *
		(DEG_M_W+RECIP_W)'(RECIP_K);

	always_comb begin
		rm_c      = m_s29 - DEG_M_W'(DEG_M_W'(d_s29) * DEG_M_W'(DEG_DEN));
		inexact_c = inx_s29 || rm_c != '0;
		if (tag_s[ST_HUE-1].eq)
			hue_c = HUE_W'(HUE_NONE);
		else if (az_s29)
			hue_c = '0;
		else if (tag_s[ST_HUE-1].bgt)
			hue_c = HUE_W'(FULL_TURN) - HUE_W'(d_s29) - HUE_W'(inexact_c);
		else
			hue_c = HUE_W'(d_s29);
	end

	assign hw_c = WW'(hue_s30);
	assign tw_c = $signed(WW'(tag_s[ST_OUT-1].tol));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[NB-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s[0] <= '{eq: in_item.r == in_item.g && in_item.g == in_item.b,
				gbz: gb_c == '0, xpos: x_c > 0, bgt: in_item.b > in_item.g,
				tol: in_item.tol};
			for (int j = 1; j < NB; j++)
				tag_s[j] <= tag_s[j-1];

			x_s1   <= x_c;
			mag_s1 <= mag_c;

			y_s2 <= CW'(prod_c >> FRAC_BITS);
			x_s2 <= CW'(x_s1) <<< ANG_SH;

			if (x_s2 < 0) begin
				cx_s[0] <= y_s2;
				cy_s[0] <= -x_s2;
				ca_s[0] <= $signed(AW'(HALF_PI_Q30));
			end else begin
				cx_s[0] <= x_s2;
				cy_s[0] <= y_s2;
				ca_s[0] <= '0;
			end

			for (int i = 0; i < CORDIC_STEPS; i++) begin
				if (cy_s[i] >= 0) begin
					cx_s[i+1] <= cx_s[i] + (cy_s[i] >>> i);
					cy_s[i+1] <= cy_s[i] - (cx_s[i] >>> i);
					ca_s[i+1] <= ca_s[i] + $signed(AW'(atan_q30(i)));
				end else begin
					cx_s[i+1] <= cx_s[i] - (cy_s[i] >>> i);
					cy_s[i+1] <= cy_s[i] + (cx_s[i] >>> i);
					ca_s[i+1] <= ca_s[i] - $signed(AW'(atan_q30(i)));
				end
			end

			a_s27  <= afin_c;
			az_s27 <= afin_c == '0;

			q_s28  <= DEG_Q_W'(a_s27) * DEG_Q_W'(DEG_NUM);
			az_s28 <= az_s27;

			m_s29   <= q_s28[DEG_Q_W-1:ANG_FRAC];
			d_s29   <= dprod_c[RECIP_SH +: DEG_D_W];
			inx_s29 <= q_s28[ANG_FRAC-1:0] != '0;
			az_s29  <= az_s28;

			hue_s30 <= hue_c;

			hue_s31 <= hue_s30;
			mr_s31  <= in_red(hw_c, WW'(red_center), tw_c);
			mb_s31  <= in_blue(hw_c, WW'(blue_center), tw_c);
		end
	end

	assign hue          = hue_s31;
	assign matches_red  = mr_s31;
	assign matches_blue = mb_s31;

endmodule

`default_nettype wire

@@ rtl/core/color_hue_classifier.sv @@
// Top level of the color hue classifier: configuration registers, front end,
// queue and back end. Depends on chc_pkg, chc_front, chc_fifo, chc_back.
//
//  channel  dir  handshake            payload
//  s_*      in   s_tvalid / s_tready  tdata: pulse_red, pulse_green, pulse_blue, tolerance
//  m_*      out  m_tvalid / m_tready  tdata: hue, matches_red, matches_blue
//  cfg_*    in   cfg_we               cfg_idx selects register, cfg_data value
//
// One transfer per cycle in and out when the output is not stalled.
// Data passes the restoring dividers, then the queue, then CORDIC (24 steps),
// degree scaling and window tests.
// Reset loads calibration defaults and empties all stages and the queue.
// An output stall freezes the back end; the four-entry queue lets the front
// end keep accepting until it fills.
`default_nettype none

module color_hue_classifier (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [55:0]                      s_tdata,  // pulse_red, pulse_green, pulse_blue, tolerance
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [15:0]                      m_tdata,  // hue, matches_red, matches_blue, zero pad
	input  logic                             cfg_we,
	input  logic [chc_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [chc_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import chc_pkg::*;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BLACK_RED   = 3'd0,
		REG_BLACK_GREEN = 3'd1,
		REG_BLACK_BLUE  = 3'd2,
		REG_WHITE_RED   = 3'd3,
		REG_WHITE_GREEN = 3'd4,
		REG_WHITE_BLUE  = 3'd5,
		REG_RED_CENTER  = 3'd6,
		REG_BLUE_CENTER = 3'd7
	} cfg_reg_t;

	cal_t                    cal_q;
	logic signed [HUE_W-1:0] red_center_q, blue_center_q;

	logic                    f_valid, f_ready, q_valid, q_ready;
	norm_item_t              f_item, q_item;
	logic signed [HUE_W-1:0] hue;
	logic                    matches_red, matches_blue;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q.black_red   <= 16'd415;
			cal_q.black_green <= 16'd475;
			cal_q.black_blue  <= 16'd357;
			cal_q.white_red   <= 16'd27;
			cal_q.white_green <= 16'd32;
			cal_q.white_blue  <= 16'd28;
			red_center_q      <= '0;
			blue_center_q     <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_idx))
				REG_BLACK_RED:   cal_q.black_red   <= cfg_data;
				REG_BLACK_GREEN: cal_q.black_green <= cfg_data;
				REG_BLACK_BLUE:  cal_q.black_blue  <= cfg_data;
				REG_WHITE_RED:   cal_q.white_red   <= cfg_data;
				REG_WHITE_GREEN: cal_q.white_green <= cfg_data;
				REG_WHITE_BLUE:  cal_q.white_blue  <= cfg_data;
				REG_RED_CENTER:  red_center_q      <= cfg_data[HUE_W-1:0];
				REG_BLUE_CENTER: blue_center_q     <= cfg_data[HUE_W-1:0];
				default: ;
			endcase
		end
	end

	chc_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_ready(s_tready),
		.pulse_red(s_tdata[15:0]), .pulse_green(s_tdata[31:16]),
		.pulse_blue(s_tdata[47:32]), .tolerance(s_tdata[55:48]),
		.cal(cal_q),
		.out_valid(f_valid), .out_ready(f_ready), .out_item(f_item)
	);

	chc_fifo u_fifo (
		.clk(clk), .arst_n(arst_n),
		.in_valid(f_valid), .in_ready(f_ready), .in_item(f_item),
		.out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
	);

	chc_back u_back (
		.clk(clk), .arst_n(arst_n),
		.in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
		.red_center(red_center_q), .blue_center(blue_center_q),
		.out_valid(m_tvalid), .out_ready(m_tready),
		.hue(hue), .matches_red(matches_red), .matches_blue(matches_blue)
	);

	assign m_tdata = {4'b0, matches_blue, matches_red, hue};

endmodule

`default_nettype wire
